>>> rtl/owb_pkg.sv
package owb_pkg;

    // Operation codes of an input item; codes above PULLUP act as ticks
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_RESET  = 3'd1;
    localparam logic [2:0] OP_WRITE  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_PULLUP = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_WAIT  = 3'd1;
    localparam logic [2:0] CFG_RESET_RECOVERY = 3'd2;
    localparam logic [2:0] CFG_WRITE_SLOT     = 3'd3;
    localparam logic [2:0] CFG_READ_SAMPLE    = 3'd4;
    localparam logic [2:0] CFG_READ_RECOVERY  = 3'd5;
    localparam logic [2:0] CFG_PULLUP         = 3'd6;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 20;
    localparam int SLOT_W      = 10;
    localparam int PULLUP_W    = 20;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 4;
    localparam int BITS_PER_BYTE = 8;

    // Timing registers as seen by the sequencer
    typedef struct packed {
        logic [SLOT_W-1:0]   reset_low_us;
        logic [SLOT_W-1:0]   presence_wait_us;
        logic [SLOT_W-1:0]   reset_recovery_us;
        logic [SLOT_W-1:0]   write_slot_us;
        logic [SLOT_W-1:0]   read_sample_us;
        logic [SLOT_W-1:0]   read_recovery_us;
        logic [PULLUP_W-1:0] pullup_us;
    } cfg_t;

    // Result of one item, handed from the sequencer to the output stage
    typedef struct packed {
        logic              drive_low;
        logic              drive_high;
        logic              busy_res;
        logic              done_res;
        logic              device_present;
        logic [BYTE_W-1:0] read_data;
        logic              rejected;
    } res_t;

endpackage

>>> rtl/owb_in_if.sv
interface owb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output operation, output data_byte, output line_level,
                    input ready);
    modport sink (input valid, input operation, input data_byte, input line_level,
                  output ready);
endinterface

>>> rtl/owb_out_if.sv
interface owb_out_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       drive_high;
    logic       busy_res;
    logic       done_res;
    logic       device_present;
    logic [7:0] read_data;
    logic       rejected;

    modport source (output valid, output drive_low, output drive_high, output busy_res,
                    output done_res, output device_present, output read_data,
                    output rejected, input ready);
    modport sink (input valid, input drive_low, input drive_high, input busy_res,
                  input done_res, input device_present, input read_data,
                  input rejected, output ready);
endinterface

>>> rtl/owb_cfg_regs.sv
module owb_cfg_regs
    import owb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Write one timing register; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_us      <= SLOT_W'(480);
            cfg_reg.presence_wait_us  <= SLOT_W'(60);
            cfg_reg.reset_recovery_us <= SLOT_W'(240);
            cfg_reg.write_slot_us     <= SLOT_W'(120);
            cfg_reg.read_sample_us    <= SLOT_W'(15);
            cfg_reg.read_recovery_us  <= SLOT_W'(90);
            cfg_reg.pullup_us         <= PULLUP_W'(1000000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_LOW:      cfg_reg.reset_low_us      <= cfg_data[SLOT_W-1:0];
                CFG_PRESENCE_WAIT:  cfg_reg.presence_wait_us  <= cfg_data[SLOT_W-1:0];
                CFG_RESET_RECOVERY: cfg_reg.reset_recovery_us <= cfg_data[SLOT_W-1:0];
                CFG_WRITE_SLOT:     cfg_reg.write_slot_us     <= cfg_data[SLOT_W-1:0];
                CFG_READ_SAMPLE:    cfg_reg.read_sample_us    <= cfg_data[SLOT_W-1:0];
                CFG_READ_RECOVERY:  cfg_reg.read_recovery_us  <= cfg_data[SLOT_W-1:0];
                CFG_PULLUP:         cfg_reg.pullup_us         <= cfg_data[PULLUP_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/owb_seq.sv
module owb_seq
    import owb_pkg::*;
#(
    parameter int TIMER_BITS = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic [2:0]  operation,
    input  logic [7:0]  data_byte,
    input  logic        line_level,
    input  cfg_t        cfg,
    output res_t        res
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_WR_START,
        PH_WR_SLOT, PH_RD_START, PH_RD_WAIT, PH_RD_REC, PH_PULLUP
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [TIMER_BITS-1:0]   tick_reg, tick_next, tick_inc, len_raw, phase_len;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next, bit_inc;
    logic [BYTE_W-1:0]       shift_reg, shift_next;
    logic                    presence_reg, presence_next;
    logic [BYTE_W-1:0]       read_reg, read_next;
    logic                    is_cmd, done, rejected;

    assign tick_inc = tick_reg + TIMER_BITS'(1);
    assign bit_inc  = bit_cnt_reg + BIT_CNT_W'(1);
    assign is_cmd   = (operation == OP_RESET) || (operation == OP_WRITE) ||
                      (operation == OP_READ) || (operation == OP_PULLUP);

    // Pick the length of the current phase; zero counts as one tick
    always_comb
    begin
        case (phase_reg)
            PH_RST_LOW:  len_raw = TIMER_BITS'(cfg.reset_low_us);
            PH_RST_WAIT: len_raw = TIMER_BITS'(cfg.presence_wait_us);
            PH_RST_REC:  len_raw = TIMER_BITS'(cfg.reset_recovery_us);
            PH_WR_SLOT:  len_raw = TIMER_BITS'(cfg.write_slot_us);
            PH_RD_WAIT:  len_raw = TIMER_BITS'(cfg.read_sample_us);
            PH_RD_REC:   len_raw = TIMER_BITS'(cfg.read_recovery_us);
            PH_PULLUP:   len_raw = TIMER_BITS'(cfg.pullup_us);
            default:     len_raw = TIMER_BITS'(1);
        endcase
        phase_len = (len_raw == '0) ? TIMER_BITS'(1) : len_raw;
    end

    // Advance the sequence by one item
    always_comb
    begin
        phase_next    = phase_reg;
        tick_next     = tick_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        presence_next = presence_reg;
        read_next     = read_reg;
        done          = 1'b0;
        rejected      = 1'b0;
        if (is_cmd)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                tick_next    = '0;
                bit_cnt_next = '0;
                shift_next   = '0;
                case (operation)
                    OP_RESET:  phase_next = PH_RST_LOW;
                    OP_WRITE:
                    begin
                        phase_next = PH_WR_START;
                        shift_next = data_byte;
                    end
                    OP_READ:   phase_next = PH_RD_START;
                    default:   phase_next = PH_PULLUP;
                endcase
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            tick_next = tick_inc;
            if (tick_inc >= phase_len)
            begin
                tick_next = '0;
                case (phase_reg)
                    PH_RST_LOW:  phase_next = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        presence_next = !line_level;
                        phase_next    = PH_RST_REC;
                    end
                    PH_WR_START: phase_next = PH_WR_SLOT;
                    PH_WR_SLOT:
                    begin
                        shift_next   = shift_reg >> 1;
                        bit_cnt_next = bit_inc;
                        if (bit_inc >= BIT_CNT_W'(BITS_PER_BYTE))
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_WR_START;
                        end
                    end
                    PH_RD_START: phase_next = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        if (line_level)
                        begin
                            shift_next[bit_cnt_reg[2:0]] = 1'b1;
                        end
                        phase_next = PH_RD_REC;
                    end
                    PH_RD_REC:
                    begin
                        bit_cnt_next = bit_inc;
                        if (bit_inc < BIT_CNT_W'(BITS_PER_BYTE))
                        begin
                            phase_next = PH_RD_START;
                        end
                        else
                        begin
                            read_next  = shift_reg;
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                endcase
            end
        end
    end

    // Build the result from the state after this item
    always_comb
    begin
        res.drive_low  = 1'b0;
        res.drive_high = 1'b0;
        case (phase_next)
            PH_RST_LOW, PH_WR_START, PH_RD_START: res.drive_low = 1'b1;
            PH_WR_SLOT: res.drive_low  = !shift_next[0];
            PH_PULLUP:  res.drive_high = 1'b1;
            default:    ;
        endcase
        res.busy_res       = (phase_next != PH_IDLE);
        res.done_res       = done;
        res.device_present = presence_next;
        res.read_data      = read_next;
        res.rejected       = rejected;
    end

    // Hold sequencer state; update on each input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            tick_reg     <= '0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            read_reg     <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            tick_reg     <= tick_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            read_reg     <= read_next;
        end
    end

    // The counter is cleared whenever the sequencer rests
    a_idle_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0))
        else $error("tick counter not clear while idle");

    // The counter stays below the length of the running phase
    a_counter_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (tick_reg < phase_len))
        else $error("tick counter ran past phase length");

    // A rejected command leaves the sequence untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && rejected) |=> ($stable(phase_reg) && $stable(tick_reg)))
        else $error("rejected command changed sequencer state");

endmodule

>>> rtl/one_wire_bus_master.sv
// Channel   Dir  Fields
// in_ch     in   operation[2:0], data_byte[7:0], line_level
// out_ch    out  drive_low, drive_high, busy_res, done_res, device_present,
//                read_data[7:0], rejected
// cfg_*     in   cfg_we, cfg_index[2:0], cfg_data[19:0]
//
// One item per clock unless the output stalls: each transfer updates the
// sequencer state; the output register holds its result on the next cycle.
// Input ready is high whenever the output register is empty or being
// drained, so the input stalls exactly in the cycles where a result waits
// with the output side stalled.
// Reset (rst_n low) returns the sequencer to idle and loads the default
// bus timings; configuration writes take effect on the next edge.
module one_wire_bus_master
    import owb_pkg::*;
#(
    parameter int TIMER_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    owb_in_if.sink                in_ch,
    owb_out_if.source             out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic in_fire;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    owb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owb_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .operation  (in_ch.operation),
        .data_byte  (in_ch.data_byte),
        .line_level (in_ch.line_level),
        .cfg        (cfg),
        .res        (res)
    );

    // Hold the result until the output transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg <= res;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.drive_low      = res_reg.drive_low;
    assign out_ch.drive_high     = res_reg.drive_high;
    assign out_ch.busy_res       = res_reg.busy_res;
    assign out_ch.done_res       = res_reg.done_res;
    assign out_ch.device_present = res_reg.device_present;
    assign out_ch.read_data      = res_reg.read_data;
    assign out_ch.rejected       = res_reg.rejected;

    // Every input transfer leaves a result waiting
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> out_valid_reg)
        else $error("input transfer produced no result");

    // The bus is never driven both ways
    a_no_contention: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(res_reg.drive_low && res_reg.drive_high))
        else $error("line driven low and high at once");

    // A finished sequence reports idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.done_res) |-> (!res_reg.busy_res && !res_reg.rejected))
        else $error("done result still busy or rejected");

endmodule

>>> sim/one_wire_bus_master_tb.sv
module one_wire_bus_master_tb;
    import owb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes 5 to 7 carry no command; the master treats them as ticks
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    // Register index with no register behind it
    localparam logic [2:0] CFG_UNUSED   = 3'd7;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 170;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_REC,
        PH_WR_START,
        PH_WR_SLOT,
        PH_RD_START,
        PH_RD_WAIT,
        PH_RD_REC,
        PH_PULLUP
    } bus_phase_t;

    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        logic       line;
        bit         typed;
        res_t       exp;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    owb_in_if  in_ch ();
    owb_out_if out_ch ();

    one_wire_bus_master dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bus sequencer mirror
    cfg_t       tim;
    bus_phase_t bphase;
    logic [19:0] tick_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift_reg;
    logic        present_flag;
    logic [7:0]  rd_byte;

    res_t bus_results_due[$];
    bit   row_typed;
    res_t row_exp;

    int idle_pct;
    int stall_pct;
    int errors;
    int stall_cycles;
    int n_items;
    int n_started[8];
    int n_rejected;
    int n_done;

    // Directed rows; lengths are all one tick except where noted at setup
    dir_row_t dir_rows [0:16] = '{
        '{OP_TICK,      8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_SPARE_LO,  8'hFF, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_SPARE_MID, 8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_SPARE_HI,  8'h5A, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_PULLUP,    8'h00, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_TICK,      8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{OP_RESET,     8'hFF, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_READ,      8'h00, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
        '{OP_TICK,      8'h00, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_TICK,      8'h00, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
        '{OP_TICK,      8'hFF, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0}},
        '{OP_WRITE,     8'hFF, 1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
        '{OP_WRITE,     8'h00, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b1}},
        '{OP_TICK,      8'h00, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_SPARE_MID, 8'h00, 1'b1, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_PULLUP,    8'hA5, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{OP_TICK,      8'h00, 1'b1, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}}
    };

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Length of the current phase in ticks; zero counts as one
    function automatic logic [19:0] phase_ticks(input bus_phase_t p);
        logic [19:0] v;
        case (p)
            PH_RST_LOW:  v = {10'd0, tim.reset_low_us};
            PH_RST_WAIT: v = {10'd0, tim.presence_wait_us};
            PH_RST_REC:  v = {10'd0, tim.reset_recovery_us};
            PH_WR_SLOT:  v = {10'd0, tim.write_slot_us};
            PH_RD_WAIT:  v = {10'd0, tim.read_sample_us};
            PH_RD_REC:   v = {10'd0, tim.read_recovery_us};
            PH_PULLUP:   v = tim.pullup_us;
            default:     v = 20'd1;
        endcase
        return (v == 20'd0) ? 20'd1 : v;
    endfunction

    // Advance the sequencer mirror by one item and form its result
    task automatic predict_bus_item(input logic [2:0] op, input logic [7:0] data,
                                    input logic line, output res_t r);
        logic finished;
        logic rej;
        finished = 1'b0;
        rej = 1'b0;
        n_items++;
        if (op >= OP_RESET && op <= OP_PULLUP) begin
            if (bphase != PH_IDLE) begin
                rej = 1'b1;
                n_rejected++;
            end
            else begin
                tick_cnt = '0;
                bit_cnt = '0;
                shift_reg = '0;
                n_started[op]++;
                case (op)
                    OP_RESET: bphase = PH_RST_LOW;
                    OP_WRITE:
                    begin
                        bphase = PH_WR_START;
                        shift_reg = data;
                    end
                    OP_READ:  bphase = PH_RD_START;
                    default:  bphase = PH_PULLUP;
                endcase
            end
        end
        else if (bphase != PH_IDLE) begin
            tick_cnt = tick_cnt + 20'd1;
            if (tick_cnt >= phase_ticks(bphase)) begin
                tick_cnt = '0;
                case (bphase)
                    PH_RST_LOW:  bphase = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        present_flag = ~line;
                        bphase = PH_RST_REC;
                    end
                    PH_WR_START: bphase = PH_WR_SLOT;
                    PH_WR_SLOT:
                    begin
                        shift_reg = shift_reg >> 1;
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt >= BITS_PER_BYTE) begin
                            bphase = PH_IDLE;
                            finished = 1'b1;
                        end
                        else begin
                            bphase = PH_WR_START;
                        end
                    end
                    PH_RD_START: bphase = PH_RD_WAIT;
                    PH_RD_WAIT:
                    begin
                        if (line)
                            shift_reg[bit_cnt[2:0]] = 1'b1;
                        bphase = PH_RD_REC;
                    end
                    PH_RD_REC:
                    begin
                        bit_cnt = bit_cnt + 4'd1;
                        if (bit_cnt < BITS_PER_BYTE) begin
                            bphase = PH_RD_START;
                        end
                        else begin
                            rd_byte = shift_reg;
                            bphase = PH_IDLE;
                            finished = 1'b1;
                        end
                    end
                    default:
                    begin
                        bphase = PH_IDLE;
                        finished = 1'b1;
                    end
                endcase
            end
        end
        if (finished)
            n_done++;

        r = '0;
        case (bphase)
            PH_RST_LOW, PH_WR_START, PH_RD_START: r.drive_low = 1'b1;
            PH_WR_SLOT: r.drive_low = ~shift_reg[0];
            PH_PULLUP:  r.drive_high = 1'b1;
            default: ;
        endcase
        r.busy_res = (bphase != PH_IDLE);
        r.done_res = finished;
        r.device_present = present_flag;
        r.read_data = rd_byte;
        r.rejected = rej;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            errors++;
        end
    endtask

    // Predict on every input transfer, check every output transfer, watch for hangs
    always @(posedge clk)
    begin : monitor
        res_t want;
        res_t got;
        bit   moved;
        if (rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                moved = 1'b1;
                predict_bus_item(in_ch.operation, in_ch.data_byte, in_ch.line_level, want);
                if (row_typed)
                    want = row_exp;
                bus_results_due.push_back(want);
            end
            if (out_ch.valid && out_ch.ready) begin
                moved = 1'b1;
                got.drive_low = out_ch.drive_low;
                got.drive_high = out_ch.drive_high;
                got.busy_res = out_ch.busy_res;
                got.done_res = out_ch.done_res;
                got.device_present = out_ch.device_present;
                got.read_data = out_ch.read_data;
                got.rejected = out_ch.rejected;
                if (bus_results_due.size() == 0) begin
                    $error("result transfer with no result pending");
                    errors++;
                end
                else begin
                    want = bus_results_due.pop_front();
                    check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
                    check_field("drive_high", 8'(want.drive_high), 8'(got.drive_high));
                    check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    check_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    check_field("device_present", 8'(want.device_present),
                                8'(got.device_present));
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("rejected", 8'(want.rejected), 8'(got.rejected));
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Result side: stall at random
    initial
    begin
        out_ch.ready = 1'b1;
    end

    always @(negedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one item and hold it until its transfer; returns at a falling edge
    task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic line,
                             input bit typed, input res_t exp);
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.operation <= op;
        in_ch.data_byte <= data;
        in_ch.line_level <= line;
        row_typed <= typed;
        row_exp <= exp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Mostly ticks, now and then a command that a busy master must refuse
    task automatic send_filler();
        logic [2:0] op;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            op = 3'($urandom_range(OP_RESET, OP_PULLUP));
        else if (pick < 85)
            op = OP_TICK;
        else
            op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        send_item(op, 8'($urandom), 1'($urandom), 1'b0, '0);
    endtask

    task automatic run_to_idle();
        while (bphase != PH_IDLE)
            send_filler();
    endtask

    // Hold the sender off until every pending result has been checked
    task automatic wait_all_results();
        in_ch.valid <= 1'b0;
        while (bus_results_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // Write every timing register, plus the spare index; junk in unused upper bits
    task automatic program_timing(input cfg_t t);
        logic [9:0] noise;
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i <= CFG_UNUSED; i++) begin
            noise = 10'($urandom);
            case (i[2:0])
                CFG_RESET_LOW:      word = {noise, t.reset_low_us};
                CFG_PRESENCE_WAIT:  word = {noise, t.presence_wait_us};
                CFG_RESET_RECOVERY: word = {noise, t.reset_recovery_us};
                CFG_WRITE_SLOT:     word = {noise, t.write_slot_us};
                CFG_READ_SAMPLE:    word = {noise, t.read_sample_us};
                CFG_READ_RECOVERY:  word = {noise, t.read_recovery_us};
                CFG_PULLUP:         word = t.pullup_us;
                default:            word = CFG_DATA_W'($urandom);
            endcase
            cfg_we <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data <= word;
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        tim = t;
        @(negedge clk);
    endtask

    function automatic logic [9:0] rand_slot();
        if ($urandom_range(9) == 0)
            return 10'($urandom_range(7, 40));
        return 10'($urandom_range(0, 6));
    endfunction

    // Stimulus
    initial
    begin
        cfg_t t;
        int pick;
        logic [2:0] op;
        logic [2:0] cmd_list [3];

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.operation = OP_TICK;
        in_ch.data_byte = '0;
        in_ch.line_level = 1'b1;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        row_typed = 1'b0;
        row_exp = '0;
        idle_pct = 0;
        stall_pct = 0;
        errors = 0;
        stall_cycles = 0;
        n_items = 0;
        n_rejected = 0;
        n_done = 0;
        foreach (n_started[i])
            n_started[i] = 0;

        // Mirror of the reset state
        tim = '{reset_low_us: 10'd480, presence_wait_us: 10'd60,
                reset_recovery_us: 10'd240, write_slot_us: 10'd120,
                read_sample_us: 10'd15, read_recovery_us: 10'd90,
                pullup_us: 20'd1000000};
        bphase = PH_IDLE;
        tick_cnt = '0;
        bit_cnt = '0;
        shift_reg = '0;
        present_flag = 1'b0;
        rd_byte = '0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Shortest lengths; a zero presence wait must act as one tick
        program_timing('{reset_low_us: 10'd1, presence_wait_us: 10'd0,
                         reset_recovery_us: 10'd1, write_slot_us: 10'd1,
                         read_sample_us: 10'd1, read_recovery_us: 10'd0,
                         pullup_us: 20'd1});
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].line,
                      dir_rows[i].typed, dir_rows[i].exp);

        // Random phases: no idling, sender idle, receiver stalling, both
        for (int p = 0; p < 4; p++) begin
            run_to_idle();
            wait_all_results();
            t.reset_low_us = rand_slot();
            t.presence_wait_us = rand_slot();
            t.reset_recovery_us = rand_slot();
            t.write_slot_us = rand_slot();
            t.read_sample_us = rand_slot();
            t.read_recovery_us = rand_slot();
            t.pullup_us = 20'($urandom_range(0, 30));
            program_timing(t);
            idle_pct = (p == 1) ? 81 : (p == 3) ? 16 : 0;
            stall_pct = (p == 2) ? 81 : (p == 3) ? 16 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 1 && i == ITEMS_PER_PHASE / 2)
                    wait_all_results();
                if (bphase == PH_IDLE) begin
                    pick = $urandom_range(99);
                    if (pick < 80)
                        op = 3'($urandom_range(OP_RESET, OP_PULLUP));
                    else if (pick < 90)
                        op = OP_TICK;
                    else
                        op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                    send_item(op, 8'($urandom), 1'($urandom), 1'b0, '0);
                end
                else begin
                    send_filler();
                end
            end
        end

        // Longer lengths: one reset, one write and one read run to the end
        run_to_idle();
        wait_all_results();
        idle_pct = 0;
        stall_pct = 0;
        program_timing('{reset_low_us: 10'd12, presence_wait_us: 10'd12,
                         reset_recovery_us: 10'd12, write_slot_us: 10'd12,
                         read_sample_us: 10'd12, read_recovery_us: 10'd12,
                         pullup_us: 20'd12});
        cmd_list = '{OP_RESET, OP_WRITE, OP_READ};
        foreach (cmd_list[i]) begin
            send_item(cmd_list[i], 8'($urandom), 1'($urandom), 1'b0, '0);
            run_to_idle();
        end

        wait_all_results();
        repeat (4) @(negedge clk);

        $display("Covered %0d items: %0d resets, %0d writes, %0d reads, %0d pull-ups started",
                 n_items, n_started[OP_RESET], n_started[OP_WRITE], n_started[OP_READ],
                 n_started[OP_PULLUP]);
        $display("%0d sequences completed, %0d busy commands refused, %0d mismatches",
                 n_done, n_rejected, errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
